### src/wsd_pkg.sv
package wsd_pkg;

  localparam logic [7:0] LEN_EXT16 = 8'd126;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;

  typedef enum logic [4:0] {
    PH_HDR0  = 5'b00001,
    PH_LEN   = 5'b00010,
    PH_EXTHI = 5'b00100,
    PH_EXTLO = 5'b01000,
    PH_DATA  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       frame_end;
    logic [3:0] frame_opcode;
  } result_t;

endpackage

### src/wsd_if.sv
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       has_byte;
  logic       frame_end;
  logic [3:0] frame_opcode;

  modport source (output valid, output payload_byte, output has_byte,
                  output frame_end, output frame_opcode, input ready);
  modport sink (input valid, input payload_byte, input has_byte,
                input frame_end, input frame_opcode, output ready);
endinterface

### src/wsd_parse.sv
module wsd_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  output wsd_pkg::result_t res
);

  logic              upgraded_r, upgraded_nxt;
  logic [1:0]        crlf_r, crlf_nxt;
  wsd_pkg::phase_t   phase_r, phase_nxt;
  logic [15:0]       left_r, left_nxt;
  logic [3:0]        opcode_r, opcode_nxt;
  logic [7:0]        len_hi_r, len_hi_nxt;
  logic [7:0]        expect_byte;
  logic [15:0]       ext_len;
  logic [15:0]       left_dec;

  assign expect_byte = crlf_r[0] ? wsd_pkg::CH_LF : wsd_pkg::CH_CR;
  assign ext_len     = {len_hi_r, rx_byte};
  assign left_dec    = (left_r == 16'd0) ? 16'd0 : left_r - 16'd1;

  always_comb begin
    upgraded_nxt = upgraded_r;
    crlf_nxt     = crlf_r;
    phase_nxt    = phase_r;
    left_nxt     = left_r;
    opcode_nxt   = opcode_r;
    len_hi_nxt   = len_hi_r;
    res          = '0;
    res.frame_opcode = opcode_r;

    if (!upgraded_r) begin
      // The match restarts at one when a mismatching byte is itself a CR.
      if (rx_byte == expect_byte) begin
        if (crlf_r == 2'd3) begin
          upgraded_nxt = 1'b1;
          crlf_nxt     = 2'd0;
        end else begin
          crlf_nxt = crlf_r + 2'd1;
        end
      end else begin
        crlf_nxt = (rx_byte == wsd_pkg::CH_CR) ? 2'd1 : 2'd0;
      end
    end else begin
      unique case (phase_r)
        wsd_pkg::PH_LEN: begin
          if (rx_byte == wsd_pkg::LEN_EXT16) begin
            phase_nxt = wsd_pkg::PH_EXTHI;
          end else if (rx_byte == 8'd0) begin
            phase_nxt     = wsd_pkg::PH_HDR0;
            res.emit      = 1'b1;
            res.frame_end = 1'b1;
          end else begin
            left_nxt  = {8'd0, rx_byte};
            phase_nxt = wsd_pkg::PH_DATA;
          end
        end
        wsd_pkg::PH_EXTHI: begin
          len_hi_nxt = rx_byte;
          phase_nxt  = wsd_pkg::PH_EXTLO;
        end
        wsd_pkg::PH_EXTLO: begin
          if (ext_len == 16'd0) begin
            phase_nxt     = wsd_pkg::PH_HDR0;
            res.emit      = 1'b1;
            res.frame_end = 1'b1;
          end else begin
            left_nxt  = ext_len;
            phase_nxt = wsd_pkg::PH_DATA;
          end
        end
        wsd_pkg::PH_DATA: begin
          left_nxt         = left_dec;
          res.emit         = 1'b1;
          res.payload_byte = rx_byte;
          res.has_byte     = 1'b1;
          res.frame_end    = (left_dec == 16'd0);
          if (left_dec == 16'd0) begin
            phase_nxt = wsd_pkg::PH_HDR0;
          end
        end
        default: begin
          opcode_nxt = rx_byte[3:0];
          phase_nxt  = wsd_pkg::PH_LEN;
        end
      endcase
    end

    if (!accept) begin
      res.emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upgraded_r <= 1'b0;
      crlf_r     <= 2'd0;
      phase_r    <= wsd_pkg::PH_HDR0;
      left_r     <= 16'd0;
      opcode_r   <= 4'd0;
      len_hi_r   <= 8'd0;
    end else if (accept) begin
      upgraded_r <= upgraded_nxt;
      crlf_r     <= crlf_nxt;
      phase_r    <= phase_nxt;
      left_r     <= left_nxt;
      opcode_r   <= opcode_nxt;
      len_hi_r   <= len_hi_nxt;
    end
  end

endmodule

### src/websocket_frame_deframer.sv
// Websocket stream deframer, one received byte per request on in_ch.
// Until the handshake terminator CR LF CR LF has been seen, every byte is
// swallowed. After that, each frame is parsed from its header (opcode
// byte, length byte, optional 16-bit big-endian extended length) and
// every payload byte is passed to out_ch with the frame opcode; the last
// payload byte carries frame_end. A zero-length frame yields one request
// with has_byte low and frame_end high. Apart from that request, header
// and handshake bytes give no output request.
// Throughput is one byte per cycle unless out_ch stalls: all parsing is a
// single combinational step from the accepted byte into the state and
// output registers; out_ch.valid rises in the cycle after acceptance.
// The output register holds its request while out_ch.ready is low; in_ch
// stays ready as long as the output register is empty or being drained
// in the same cycle, so a stall holds off the input whenever a request is
// waiting in the output register.
// Synchronous reset (rst_n low) returns the block to the pre-handshake
// state and empties the output register.
module websocket_frame_deframer (
  input  logic      clk,
  input  logic      rst_n,
  wsd_in_if.sink    in_ch,
  wsd_out_if.source out_ch
);

  wsd_pkg::result_t res;
  logic             accept;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_has_r;
  logic             out_end_r;
  logic [3:0]       out_opcode_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  wsd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_ch.rx_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.emit) begin
      out_byte_r   <= res.payload_byte;
      out_has_r    <= res.has_byte;
      out_end_r    <= res.frame_end;
      out_opcode_r <= res.frame_opcode;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.payload_byte = out_byte_r;
  assign out_ch.has_byte     = out_has_r;
  assign out_ch.frame_end    = out_end_r;
  assign out_ch.frame_opcode = out_opcode_r;

endmodule

### dv/tb_websocket_frame_deframer.sv
module tb_websocket_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned HOLDOFF_LEN   = 300;
  localparam int unsigned RANDOM_BYTES  = 500;
  localparam int unsigned SETTLE_CYCLES = 20;

  // Predicts the payload requests of the deframer from the bytes it accepts
  // and checks the requests it returns in order.
  class payload_scoreboard;
    bit                        upgraded;
    int unsigned               crlf_seen;
    wsd_pkg::phase_t           phase;
    logic [15:0]               len_left;
    logic [3:0]                opcode;
    logic [7:0]                len_hi;
    wsd_pkg::result_t          expected_payload_q[$];
    int unsigned               errors;

    function new();
      upgraded  = 1'b0;
      crlf_seen = 0;
      phase     = wsd_pkg::PH_HDR0;
      len_left  = '0;
      opcode    = '0;
      len_hi    = '0;
      errors    = 0;
    endfunction

    function void push_payload(logic [7:0] data, logic has, logic last);
      wsd_pkg::result_t r;
      r.emit         = 1'b1;
      r.payload_byte = data;
      r.has_byte     = has;
      r.frame_end    = last;
      r.frame_opcode = opcode;
      expected_payload_q.push_back(r);
    endfunction

    function void note_rx_byte(logic [7:0] b);
      logic [7:0]  want;
      logic [15:0] ext_len;
      if (!upgraded) begin
        want = (crlf_seen % 2 == 0) ? wsd_pkg::CH_CR : wsd_pkg::CH_LF;
        if (b == want) begin
          crlf_seen++;
        end else begin
          crlf_seen = (b == wsd_pkg::CH_CR) ? 1 : 0;
        end
        if (crlf_seen >= 4) begin
          upgraded  = 1'b1;
          crlf_seen = 0;
        end
        return;
      end
      case (phase)
        wsd_pkg::PH_LEN: begin
          if (b == wsd_pkg::LEN_EXT16) begin
            phase = wsd_pkg::PH_EXTHI;
          end else if (b == 8'd0) begin
            phase = wsd_pkg::PH_HDR0;
            push_payload(8'd0, 1'b0, 1'b1);
          end else begin
            len_left = {8'd0, b};
            phase    = wsd_pkg::PH_DATA;
          end
        end
        wsd_pkg::PH_EXTHI: begin
          len_hi = b;
          phase  = wsd_pkg::PH_EXTLO;
        end
        wsd_pkg::PH_EXTLO: begin
          ext_len = {len_hi, b};
          if (ext_len == 16'd0) begin
            phase = wsd_pkg::PH_HDR0;
            push_payload(8'd0, 1'b0, 1'b1);
          end else begin
            len_left = ext_len;
            phase    = wsd_pkg::PH_DATA;
          end
        end
        wsd_pkg::PH_DATA: begin
          if (len_left != 16'd0) begin
            len_left = len_left - 16'd1;
          end
          if (len_left == 16'd0) begin
            phase = wsd_pkg::PH_HDR0;
          end
          push_payload(b, 1'b1, len_left == 16'd0);
        end
        default: begin
          opcode = b[3:0];
          phase  = wsd_pkg::PH_LEN;
        end
      endcase
    endfunction

    function void compare_field(string field, int unsigned exp_val,
                                int unsigned got_val);
      if (exp_val != got_val) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_payload(wsd_pkg::result_t got);
      wsd_pkg::result_t exp_r;
      if (expected_payload_q.size() == 0) begin
        $error({"unexpected request: payload_byte 0x%0h has_byte %0d",
                " frame_end %0d opcode 0x%0h"},
               got.payload_byte, got.has_byte, got.frame_end, got.frame_opcode);
        errors++;
        return;
      end
      exp_r = expected_payload_q.pop_front();
      compare_field("payload_byte", 32'(exp_r.payload_byte), 32'(got.payload_byte));
      compare_field("has_byte", 32'(exp_r.has_byte), 32'(got.has_byte));
      compare_field("frame_end", 32'(exp_r.frame_end), 32'(got.frame_end));
      compare_field("frame_opcode", 32'(exp_r.frame_opcode), 32'(got.frame_opcode));
    endfunction

    function int unsigned pending();
      return expected_payload_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  wsd_in_if  in_ch();
  wsd_out_if out_ch();

  websocket_frame_deframer u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  payload_scoreboard sb;
  int unsigned       bytes_sent;
  int unsigned       sender_quiet_left;
  bit                sender_burst;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (sender_burst) begin
      gap = 0;
    end else if (sender_quiet_left > 0) begin
      gap = 0;
      sender_quiet_left--;
    end else begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 31) == 0) begin
        sender_quiet_left = $urandom_range(10, 40);
      end
    end
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] hdr, input logic [15:0] len, input bit use_ext);
    send_byte(hdr);
    if (use_ext) begin
      send_byte(wsd_pkg::LEN_EXT16);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else begin
      send_byte(len[7:0]);
    end
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_random_frame();
    int unsigned sel;
    logic [7:0]  hdr;
    hdr = 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      send_frame(hdr, 16'd0, 1'b0);
    end else if (sel < 65) begin
      send_frame(hdr, 16'($urandom_range(1, 8)), 1'b0);
    end else if (sel < 80) begin
      send_frame(hdr, 16'($urandom_range(9, 125)), 1'b0);
    end else if (sel < 84) begin
      // Short codes above the extended-length marker are taken whole.
      send_frame(hdr, 16'($urandom_range(127, 255)), 1'b0);
    end else if (sel < 94) begin
      send_frame(hdr, 16'($urandom_range(0, 12)), 1'b1);
    end else begin
      send_frame(hdr, 16'($urandom_range(0, 400)), 1'b1);
    end
  endtask

  // Stops offering bytes until every predicted request has come back.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin : result_sink
    int unsigned      stall;
    int unsigned      quiet_left;
    int unsigned      results_taken;
    wsd_pkg::result_t got;
    quiet_left    = 0;
    results_taken = 0;
    out_ch.ready  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (results_taken == 100 || results_taken == 5000) begin
        // Long hold-off so that the output register fills and the input stalls.
        stall = HOLDOFF_LEN;
      end else if (quiet_left > 0) begin
        stall = 0;
        quiet_left--;
      end else begin
        stall = $urandom_range(0, 10);
        if ($urandom_range(0, 31) == 0) begin
          quiet_left = $urandom_range(10, 60);
        end
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.emit         = 1'b1;
      got.payload_byte = out_ch.payload_byte;
      got.has_byte     = out_ch.has_byte;
      got.frame_end    = out_ch.frame_end;
      got.frame_opcode = out_ch.frame_opcode;
      sb.check_payload(got);
      results_taken++;
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    // Handshake noise with partial and overlapping terminators, then a few
    // hand-picked frames: empty, empty extended, single byte, two bytes.
    logic [7:0] directed_bytes [30];
    bit paused;
    directed_bytes = '{
      wsd_pkg::CH_LF, wsd_pkg::CH_CR, wsd_pkg::CH_LF, 8'h00,
      wsd_pkg::CH_CR, wsd_pkg::CH_LF, wsd_pkg::CH_CR, 8'hff,
      wsd_pkg::CH_CR, wsd_pkg::CH_LF, wsd_pkg::CH_CR, wsd_pkg::CH_CR,
      wsd_pkg::CH_LF, wsd_pkg::CH_CR, wsd_pkg::CH_LF,
      8'h81, 8'h00,
      8'h0f, wsd_pkg::LEN_EXT16, 8'h00, 8'h00,
      8'hf0, 8'h01, 8'hff,
      8'h82, wsd_pkg::LEN_EXT16, 8'h00, 8'h02, 8'h5a, 8'ha5
    };
    sb                = new();
    bytes_sent        = 0;
    sender_quiet_left = 0;
    sender_burst      = 1'b0;
    paused            = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.rx_byte     = 8'h00;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_bytes[i]) begin
      send_byte(directed_bytes[i]);
    end

    while (bytes_sent < RANDOM_BYTES) begin
      send_random_frame();
      if (!paused && bytes_sent >= RANDOM_BYTES / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    // One long extended-length frame with a nonzero high byte, offered back to back.
    sender_burst = 1'b1;
    send_frame(8'($urandom_range(0, 255)), 16'h0101, 1'b1);
    sender_burst = 1'b0;
    repeat (3) send_random_frame();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
